// File: hw/rtl/tfpa_pkg.sv
// shared types and constants of the tracker frame parser and averager
package tfpa_pkg;

  localparam int unsigned COORD_W = 16;

  localparam logic [7:0] SYNC_FIRST  = 8'h80;
  localparam logic [7:0] SYNC_SECOND = 8'h83;

  // parser phase: hunting, first sync seen, then data bytes taken
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC,
    PH_D0,
    PH_D1,
    PH_D2,
    PH_D3,
    PH_D4,
    PH_D5
  } phase_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pos_t;

  // load strobes of the divide stages
  typedef struct packed {
    logic mag_load;
    logic prod_load;
  } div_ctl_t;

endpackage

// File: hw/rtl/tfpa_if.sv
// channel interfaces: received bytes, results, enable register write
interface tfpa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tfpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] mean_x;
  logic signed [15:0] mean_y;
  logic signed [15:0] mean_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output mean_x, output mean_y, output mean_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input mean_x, input mean_y, input mean_z, output ready);
endinterface

interface tfpa_cfg_if;
  logic valid;
  logic ready;
  logic enable;

  modport source (output valid, output enable, input ready);
  modport sink (input valid, input enable, output ready);
endinterface

// File: hw/rtl/tfpa_cell.sv
// one history cell: holds one stored position, passes it on when a frame arrives
module tfpa_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  input  tfpa_pkg::pos_t d,
  output tfpa_pkg::pos_t q
);
  import tfpa_pkg::*;

  pos_t val_r;
  pos_t val_nxt;

  always_comb begin
    val_nxt = shift ? d : val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign q = val_r;
endmodule

// File: hw/rtl/tfpa_div.sv
// signed divide by the history depth, truncating toward zero, two stages
module tfpa_div #(
  parameter int unsigned DEPTH = 5,
  parameter int unsigned SUM_W = 19
) (
  input  logic                    clk,
  input  tfpa_pkg::div_ctl_t      ctl,
  input  logic signed [SUM_W-1:0] sum,
  output logic signed [15:0]      quot
);
  import tfpa_pkg::*;

  // reciprocal exact for every magnitude below 2**SUM_W
  localparam int unsigned SHIFT = SUM_W + $clog2(DEPTH);
  localparam logic [63:0] MULT_WIDE =
    ((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
  localparam logic [SHIFT:0] MULT = MULT_WIDE[SHIFT:0];
  localparam int unsigned PROD_W = SUM_W + SHIFT + 1;

  logic [SUM_W-1:0]  mag_r;
  logic [SUM_W-1:0]  mag_nxt;
  logic              neg_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic              neg2_r;
  logic [16:0]       q_mag;
  logic [16:0]       q_signed;

  always_comb begin
    mag_nxt  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    prod_nxt = PROD_W'(mag_r) * PROD_W'(MULT);
  end

  always_ff @(posedge clk) begin
    if (ctl.mag_load) begin
      mag_r <= mag_nxt;
      neg_r <= sum[SUM_W-1];
    end
    if (ctl.prod_load) begin
      prod_r <= prod_nxt;
      neg2_r <= neg_r;
    end
  end

  // magnitude of the quotient is at most 32768
  assign q_mag    = prod_r[SHIFT +: 17];
  assign q_signed = neg2_r ? (17'd0 - q_mag) : q_mag;
  assign quot     = q_signed[15:0];
endmodule

// File: hw/rtl/tracker_frame_parser_averager.sv
// top level: frame parser, history cell chain, running sums and mean pipeline
// a frame's result passes s1, s2, s3 and the output register in turn
// throughput: one byte per cycle; one result per frame, so at most one per 8 bytes
// the last byte of a frame waits only if the first result stage is still held
// reset: synchronous, active low; parser hunts, history cells and sums clear
// to zero, enable clears to 0, no result pending
module tracker_frame_parser_averager #(
  parameter int unsigned HISTORY_DEPTH = 5
) (
  input logic        clk,
  input logic        rst_n,
  tfpa_in_if.sink    in_if,
  tfpa_out_if.source out_if,
  tfpa_cfg_if.sink   cfg_if
);
  import tfpa_pkg::*;

  // sum of HISTORY_DEPTH signed 16-bit values
  localparam int unsigned SUM_W = COORD_W + $clog2(HISTORY_DEPTH);

  // configuration: always ready; the user must write it only while idle, not enforced here
  logic enable_r;
  logic enable_nxt;

  assign cfg_if.ready = 1'b1;
  assign enable_nxt   = (cfg_if.valid && cfg_if.ready) ? cfg_if.enable : enable_r;

  // ---------------- parser ----------------
  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [39:0] partial_r;
  logic [39:0] partial_nxt;
  logic        in_accept;
  logic        capture_byte;
  logic        frame_done;
  logic        s1_free;
  logic        in_ready;
  pos_t        new_pos;

  assign in_accept = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_accept) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_if.rx_byte == SYNC_FIRST) phase_nxt = PH_SYNC;
        end
        PH_SYNC: begin
          // a bad second byte is looked at again as a first sync byte
          if (in_if.rx_byte == SYNC_SECOND) phase_nxt = PH_D0;
          else if (in_if.rx_byte != SYNC_FIRST) phase_nxt = PH_HUNT;
        end
        PH_D0:   phase_nxt = PH_D1;
        PH_D1:   phase_nxt = PH_D2;
        PH_D2:   phase_nxt = PH_D3;
        PH_D3:   phase_nxt = PH_D4;
        PH_D4:   phase_nxt = PH_D5;
        PH_D5:   phase_nxt = PH_HUNT;
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // parser outputs
  always_comb begin
    in_ready     = 1'b1;
    capture_byte = 1'b0;
    frame_done   = 1'b0;
    case (phase_r)
      PH_HUNT, PH_SYNC: begin
        in_ready = 1'b1;
      end
      PH_D0, PH_D1, PH_D2, PH_D3, PH_D4: begin
        capture_byte = in_if.valid;
      end
      PH_D5: begin
        // the frame needs a free first result stage
        in_ready   = s1_free;
        frame_done = in_if.valid && s1_free;
      end
      default: begin
        in_ready = 1'b1;
      end
    endcase
  end

  assign partial_nxt = capture_byte ? {partial_r[31:0], in_if.rx_byte} : partial_r;

  // big-endian coordinates, last byte straight from the input
  assign new_pos.x = {partial_r[39:32], partial_r[31:24]};
  assign new_pos.y = {partial_r[23:16], partial_r[15:8]};
  assign new_pos.z = {partial_r[7:0], in_if.rx_byte};

  // ---------------- history cell chain ----------------
  // each frame enters the first cell and every cell hands its entry on;
  // the mean does not depend on order, so a shift chain serves as the ring
  pos_t cell_q [HISTORY_DEPTH];

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    pos_t cell_d;
    if (i == 0) begin : g_first
      assign cell_d = new_pos;
    end else begin : g_next
      assign cell_d = cell_q[i-1];
    end
    tfpa_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (frame_done),
      .d     (cell_d),
      .q     (cell_q[i])
    );
  end

  // running sums: add the new entry, drop the one leaving the last cell
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [SUM_W-1:0] sum_x_nxt, sum_y_nxt, sum_z_nxt;
  pos_t                    oldest;

  assign oldest = cell_q[HISTORY_DEPTH-1];

  always_comb begin
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    sum_z_nxt = sum_z_r;
    if (frame_done) begin
      sum_x_nxt = sum_x_r + SUM_W'(new_pos.x) - SUM_W'(oldest.x);
      sum_y_nxt = sum_y_r + SUM_W'(new_pos.y) - SUM_W'(oldest.y);
      sum_z_nxt = sum_z_r + SUM_W'(new_pos.z) - SUM_W'(oldest.z);
    end
  end

  // ---------------- result pipeline ----------------
  // s1: position and sums ready, s2: magnitudes, s3: products, then output
  logic     s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic     s1_v_nxt, s2_v_nxt, s3_v_nxt, out_v_nxt;
  logic     s2_load, s3_load, out_load;
  logic     s2_free, s3_free;
  pos_t     pos_s1_r, pos_s2_r, pos_s3_r;
  div_ctl_t div_ctl;

  // a stage takes the next item when it is empty or its item moves on
  assign out_load = s3_v_r && (!out_v_r || out_if.ready);
  assign s3_free  = !s3_v_r || out_load;
  assign s3_load  = s2_v_r && s3_free;
  assign s2_free  = !s2_v_r || s3_load;
  assign s2_load  = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_load;

  assign s1_v_nxt  = frame_done || (s1_v_r && !s2_load);
  assign s2_v_nxt  = s2_load || (s2_v_r && !s3_load);
  assign s3_v_nxt  = s3_load || (s3_v_r && !out_load);
  assign out_v_nxt = out_load || (out_v_r && !out_if.ready);

  assign div_ctl.mag_load  = s2_load;
  assign div_ctl.prod_load = s3_load;

  logic signed [15:0] q_x, q_y, q_z;

  // the sums stay put while s1 is full and held, since no frame completes then
  tfpa_div #(.DEPTH(HISTORY_DEPTH), .SUM_W(SUM_W)) u_div_x (
    .clk (clk), .ctl (div_ctl), .sum (sum_x_r), .quot (q_x)
  );
  tfpa_div #(.DEPTH(HISTORY_DEPTH), .SUM_W(SUM_W)) u_div_y (
    .clk (clk), .ctl (div_ctl), .sum (sum_y_r), .quot (q_y)
  );
  tfpa_div #(.DEPTH(HISTORY_DEPTH), .SUM_W(SUM_W)) u_div_z (
    .clk (clk), .ctl (div_ctl), .sum (sum_z_r), .quot (q_z)
  );

  // output register
  pos_t               out_pos_r;
  logic signed [15:0] mean_x_r, mean_y_r, mean_z_r;

  always_ff @(posedge clk) begin
    if (frame_done) pos_s1_r <= new_pos;
    if (s2_load)    pos_s2_r <= pos_s1_r;
    if (s3_load)    pos_s3_r <= pos_s2_r;
    if (out_load) begin
      out_pos_r <= pos_s3_r;
      // averaged outputs read zero while disabled
      mean_x_r  <= enable_r ? q_x : 16'sd0;
      mean_y_r  <= enable_r ? q_y : 16'sd0;
      mean_z_r  <= enable_r ? q_z : 16'sd0;
    end
    partial_r <= partial_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      enable_r <= 1'b0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      sum_z_r  <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      enable_r <= enable_nxt;
      sum_x_r  <= sum_x_nxt;
      sum_y_r  <= sum_y_nxt;
      sum_z_r  <= sum_z_nxt;
      s1_v_r   <= s1_v_nxt;
      s2_v_r   <= s2_v_nxt;
      s3_v_r   <= s3_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  assign out_if.valid  = out_v_r;
  assign out_if.pos_x  = out_pos_r.x;
  assign out_if.pos_y  = out_pos_r.y;
  assign out_if.pos_z  = out_pos_r.z;
  assign out_if.mean_x = mean_x_r;
  assign out_if.mean_y = mean_y_r;
  assign out_if.mean_z = mean_z_r;

  // ---------------- checks ----------------
  // a completed frame always lands in the first result stage
  a_frame_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready && phase_r == PH_D5 |=> s1_v_r)
    else $error("completed frame did not enter result pipeline");

  // a held first stage blocks the last byte of the next frame
  a_s1_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_D5 && s1_v_r && !s2_load |-> !in_if.ready)
    else $error("frame accepted while first result stage full");

  // a stage item that cannot move is not lost
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !out_load |=> s3_v_r)
    else $error("result dropped in third stage");

  // sums change only when a frame completes
  a_sum_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_done |=> $stable(sum_x_r) && $stable(sum_y_r) && $stable(sum_z_r))
    else $error("history sum changed without a frame");

endmodule

// File: tb/sv/tb_top.sv
// testbench for the tracker frame parser and averager: random byte streams checked per frame
`timescale 1ns / 1ps

module tb_top;
  import tfpa_pkg::*;

  localparam int HIST_DEPTH   = 5;
  localparam int DRAIN_CYCLES = 12;      // result passes s1, s2, s3 and the output register after the last byte
  localparam int HOLD_CYCLES  = 300;     // long output hold, enough to back up the input
  localparam int CYCLE_LIMIT  = 400000;  // watchdog limit on the whole run

  // one expected or observed result item
  typedef struct packed {
    pos_t pos;
    pos_t mean;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;

  tfpa_in_if  in_ch ();
  tfpa_out_if out_ch ();
  tfpa_cfg_if cfg_ch ();

  tracker_frame_parser_averager #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  always #5 clk = ~clk;

  // stimulus bookkeeping
  logic [7:0]    pending_bytes[$];
  frame_result_t expected_frames[$];
  int            bytes_queued = 0;
  int            bytes_accepted = 0;
  int            frames_checked = 0;
  int            mismatches = 0;
  int            cycle_count = 0;
  bit            hold_armed = 1'b0;
  bit            hold_done = 1'b0;

  // predictor state: parser, partial frame, history ring, enable
  phase_t        parse_state = PH_HUNT;
  logic [7:0]    data_bytes[5];
  pos_t          hist_ring[HIST_DEPTH];
  int            ring_slot = 0;
  logic          enable_reg = 1'b0;

  initial begin
    for (int k = 0; k < HIST_DEPTH; k++) hist_ring[k] = '0;
    for (int k = 0; k < 5; k++) data_bytes[k] = '0;
  end

  // advance the parser by one received byte; a completed frame queues one result
  task automatic absorb_rx_byte(input logic [7:0] b);
    frame_result_t res;
    int sum_x, sum_y, sum_z;
    case (parse_state)
      PH_HUNT: begin
        if (b == SYNC_FIRST) parse_state = PH_SYNC;
      end
      PH_SYNC: begin
        // a wrong second sync byte is looked at again as a first sync byte
        if (b == SYNC_SECOND) parse_state = PH_D0;
        else if (b != SYNC_FIRST) parse_state = PH_HUNT;
      end
      PH_D5: begin
        res.pos.x = {data_bytes[0], data_bytes[1]};
        res.pos.y = {data_bytes[2], data_bytes[3]};
        res.pos.z = {data_bytes[4], b};
        hist_ring[ring_slot] = res.pos;
        ring_slot = (ring_slot == HIST_DEPTH - 1) ? 0 : ring_slot + 1;
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        // unwritten entries are zero, so the whole ring is always summed
        for (int k = 0; k < HIST_DEPTH; k++) begin
          sum_x += hist_ring[k].x;
          sum_y += hist_ring[k].y;
          sum_z += hist_ring[k].z;
        end
        // int division truncates toward zero
        if (enable_reg) begin
          res.mean.x = 16'(sum_x / HIST_DEPTH);
          res.mean.y = 16'(sum_y / HIST_DEPTH);
          res.mean.z = 16'(sum_z / HIST_DEPTH);
        end else begin
          res.mean = '0;
        end
        expected_frames.push_back(res);
        parse_state = PH_HUNT;
      end
      default: begin
        // data bytes are taken whatever their value, sync codes included
        data_bytes[int'(parse_state) - int'(PH_D0)] = b;
        parse_state = phase_t'(parse_state + 3'd1);
      end
    endcase
  endtask

  // no idling at all for one stretch in every five
  function automatic bit steady_window();
    return ((cycle_count / 1500) % 5) == 2;
  endfunction

  function automatic int pick_send_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_window() || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input driver: pops pending bytes, idles at random between items
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= 8'h00;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_rx_byte(in_ch.rx_byte);
        bytes_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_ch.valid   <= 1'b1;
          in_ch.rx_byte <= pending_bytes.pop_front();
          send_gap = pick_send_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready: short random stalls, plus one long hold while bytes keep coming
  int stall_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_armed && hold_left == 0 && in_ch.valid) begin
        hold_left  = HOLD_CYCLES;
        hold_armed = 1'b0;
        hold_done  = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady_window() && $urandom_range(0, 99) < 20)
          stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                    : $urandom_range(8, 40);
      end
    end
  end

  task automatic compare_coord(input string field, input logic signed [15:0] want,
                               input logic signed [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  // result monitor: every accepted result against the oldest expectation
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none actual pos %0d %0d %0d",
                 $time, out_ch.pos_x, out_ch.pos_y, out_ch.pos_z);
      end else begin
        want = expected_frames.pop_front();
        compare_coord("pos_x", want.pos.x, out_ch.pos_x);
        compare_coord("pos_y", want.pos.y, out_ch.pos_y);
        compare_coord("pos_z", want.pos.z, out_ch.pos_z);
        compare_coord("mean_x", want.mean.x, out_ch.mean_x);
        compare_coord("mean_y", want.mean.y, out_ch.mean_y);
        compare_coord("mean_z", want.mean.z, out_ch.mean_z);
        frames_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tracker_frame_parser_averager test failed");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
    queue_byte(SYNC_FIRST);
    queue_byte(SYNC_SECOND);
    queue_byte(x[15:8]);
    queue_byte(x[7:0]);
    queue_byte(y[15:8]);
    queue_byte(y[7:0]);
    queue_byte(z[15:8]);
    queue_byte(z[7:0]);
  endtask

  // data bytes lean toward sync codes and sign boundaries
  function automatic logic [7:0] random_data_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return ($urandom_range(0, 1) != 0) ? SYNC_FIRST : SYNC_SECOND;
    if (r < 20) begin
      case ($urandom_range(0, 2))
        0: return 8'h00;
        1: return 8'hFF;
        default: return 8'h7F;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly clean frames, some line noise, some broken sync or cut-off frames
  task automatic queue_random_traffic(input int n_bytes);
    int start;
    int r;
    logic [7:0] b;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        queue_frame({random_data_byte(), random_data_byte()},
                    {random_data_byte(), random_data_byte()},
                    {random_data_byte(), random_data_byte()});
      end else if (r < 88) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 1) != 0) begin
        queue_byte(SYNC_FIRST);
        do b = 8'($urandom_range(0, 255)); while (b == SYNC_SECOND);
        queue_byte(b);
      end else begin
        // frame cut short: the next sync pair lands in its data
        queue_byte(SYNC_FIRST);
        queue_byte(SYNC_SECOND);
        repeat ($urandom_range(0, 5)) queue_byte(random_data_byte());
      end
    end
  endtask

  // sender pause: everything accepted, every result back, pipeline flushed
  task automatic wait_idle();
    do @(posedge clk);
    while (bytes_accepted != bytes_queued || expected_frames.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    cfg_ch.valid  <= 1'b1;
    cfg_ch.enable <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    enable_reg = v;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.enable = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, enable still at reset value so means read zero
    queue_byte(8'h13);
    queue_byte(SYNC_FIRST);
    queue_byte(8'h55);                          // bad second sync back to hunting
    queue_byte(SYNC_FIRST);                     // repeated first sync keeps sync-seen
    queue_frame(16'h7FFF, 16'h8000, 16'h0000);
    queue_frame(16'h8083, 16'hFFFF, 16'h8380);  // sync codes inside data
    queue_frame(16'h0001, 16'hFFFE, 16'h8001);
    wait_idle();

    // enable on: fill the ring at both extremes, then random traffic
    write_enable(1'b1);
    repeat (6) queue_frame(16'h8000, 16'h8000, 16'h8000);
    repeat (6) queue_frame(16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_frame(16'hFFFF, 16'h0001, 16'h0000);
    wait_idle();
    hold_armed = 1'b1;
    queue_random_traffic(700);
    wait_idle();

    write_enable(1'b0);
    queue_random_traffic(400);
    wait_idle();

    write_enable(1'b1);
    queue_random_traffic(700);
    wait_idle();

    if (expected_frames.size() != 0) mismatches++;
    $display("run covered %0d bytes and %0d checked frames, enable written 1, 0, 1",
             bytes_accepted, frames_checked);
    $display("ring filled at both coordinate extremes, long output hold %s",
             hold_done ? "applied" : "not applied");
    if (mismatches == 0)
      $display("tracker_frame_parser_averager test passed");
    else
      $display("tracker_frame_parser_averager test failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tfpa_pkg.sv
hw/rtl/tfpa_if.sv
hw/rtl/tfpa_cell.sv
hw/rtl/tfpa_div.sv
hw/rtl/tracker_frame_parser_averager.sv
tb/sv/tb_top.sv
